[design/sfc_pkg.sv]
// Package for the scaled fast clock: time record type, mode flag bits,
// limits and the packet time loader. No dependencies.
package sfc_pkg;

  // Prescaler period in ticks per decisecond.
  localparam logic [4:0] TICKS_PER_TENTH = 5'd11;

  // Source address that accepts packets from any sender.
  localparam logic [7:0] ADDR_ANY = 8'hFF;

  // Shortest packet that carries the fast time section.
  localparam logic [7:0] PKT_FAST_LEN = 8'd14;

  // Configuration register indexes.
  localparam logic CFG_SOURCE_ADDRESS = 1'b0;
  localparam logic CFG_TIMEOUT_LIMIT  = 1'b1;

  // Mode flag bit positions.
  localparam int FLAG_FAST    = 0;
  localparam int FLAG_HOLD    = 1;
  localparam int FLAG_REAL_12 = 2;
  localparam int FLAG_FAST_12 = 3;

  // Clock mode codes.
  localparam logic [1:0] MODE_REAL      = 2'd0;
  localparam logic [1:0] MODE_FAST_RUN  = 2'd1;
  localparam logic [1:0] MODE_FAST_HOLD = 2'd2;
  localparam logic [1:0] MODE_HOLD_ONLY = 2'd3;

  // One time of day.
  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } hms_t;

  // Loads a packet time; any field out of range gives midnight.
  function automatic hms_t load_hms(input logic [7:0] h, input logic [7:0] m,
                                    input logic [7:0] s);
    hms_t t;
    if (h >= 8'd24 || m >= 8'd60 || s >= 8'd60) begin
      t = '0;
    end else begin
      t.hours   = h[4:0];
      t.minutes = m[5:0];
      t.seconds = s[5:0];
    end
    return t;
  endfunction

endpackage

[design/scaled_fast_clock_with_sync_unit.sv]
// Scaled fast clock top level: packet loading, tick prescaler, fast time
// advance and the result register. Depends on sfc_pkg.
//
// Usage: every input beat is either a timer tick (req_type 0) or a received
// time packet (req_type 1) and yields exactly one result beat, carrying the
// real and fast times (zero while timed out), the clock mode and the 12-hour
// display flags. Both channels use valid/ready.
// The result of a beat accepted at one edge is valid from that edge on.
// Throughput is one beat per cycle while results are taken; the state update
// and the result are one pass of logic into the state and result registers.
// A packet splits the scale factor into whole minutes, seconds, deciseconds
// and tenths of a decisecond as it is loaded (three constant reciprocal
// products), so a decisecond step needs only narrow compare-and-subtract
// carries.
// When the receiver stalls, the result register holds and the input side
// takes a new beat only in the cycle in which the waiting result is taken.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once.
// Reset clears all time and mode state, sets the source address to any and
// the timeout limit to 50; the block reports timed out until the first
// packet unless the limit is written as zero.
module scaled_fast_clock_with_sync_unit
  import sfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // Configuration port.
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  // Input channel.
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       req_type,
  input  logic [7:0] src_addr,
  input  logic [7:0] pkt_length,
  input  logic [7:0] rx_real_hours,
  input  logic [7:0] rx_real_minutes,
  input  logic [7:0] rx_real_seconds,
  input  logic [7:0] rx_mode_flags,
  input  logic [7:0] rx_fast_hours,
  input  logic [7:0] rx_fast_minutes,
  input  logic [7:0] rx_fast_seconds,
  input  logic [15:0] rx_scale,
  // Output channel.
  output logic       out_valid,
  input  logic       out_ready,
  output logic       packet_taken,
  output logic       timed_out,
  output logic [1:0] clock_mode,
  output logic       fast_ampm,
  output logic       real_ampm,
  output logic [4:0] fast_hours_out,
  output logic [5:0] fast_minutes_out,
  output logic [5:0] fast_seconds_out,
  output logic [4:0] real_hours_out,
  output logic [5:0] real_minutes_out,
  output logic [5:0] real_seconds_out
);

  // Configuration registers.
  logic [7:0] source_address;
  logic [7:0] timeout_limit;

  // Clock state.
  logic [3:0] tick_prescale, tick_prescale_next;
  logic [7:0] timeout_count, timeout_count_next;
  logic [3:0] decisec_accum, decisec_accum_next;
  logic [3:0] tenths_accum, tenths_accum_next;
  logic [3:0] mode_flags, mode_flags_next;
  hms_t       real_time, real_time_next;
  hms_t       fast_time, fast_time_next;

  // Scale factor split as minutes, seconds, deciseconds and tenths.
  logic [3:0] scale_min, scale_min_next;
  logic [5:0] scale_sec, scale_sec_next;
  logic [3:0] scale_dsec, scale_dsec_next;
  logic [3:0] scale_tenth, scale_tenth_next;

  logic accept;
  logic taken;
  logic timed_out_next;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      source_address <= ADDR_ANY;
      timeout_limit  <= 8'd50;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SOURCE_ADDRESS: source_address <= cfg_data;
        CFG_TIMEOUT_LIMIT:  timeout_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Scale split by reciprocal products: /10, /100 and /6000, each exact over
  // the full 16-bit range.
  logic [31:0] prod_d10;
  logic [32:0] prod_d100;
  logic [32:0] prod_d6000;
  logic [12:0] scale_q10;
  logic [9:0]  scale_q100;
  logic [3:0]  scale_q6000;
  logic [15:0] tenth_full;
  logic [12:0] dsec_full;
  logic [9:0]  sec_full;

  always_comb begin
    prod_d10    = {16'd0, rx_scale} * 32'd52429;
    prod_d100   = {17'd0, rx_scale} * 33'd83887;
    prod_d6000  = {17'd0, rx_scale} * 33'd89479;
    scale_q10   = prod_d10[31:19];
    scale_q100  = prod_d100[32:23];
    scale_q6000 = prod_d6000[32:29];
    tenth_full  = rx_scale - ({3'd0, scale_q10} << 3) - ({3'd0, scale_q10} << 1);
    dsec_full   = scale_q10 - ({3'd0, scale_q100} << 3) - ({3'd0, scale_q100} << 1);
    sec_full    = scale_q100 - ({6'd0, scale_q6000} << 6) + ({6'd0, scale_q6000} << 2);
  end

  // Decisecond step: prescaler, tenths and decisecond carries, fast time.
  logic [4:0] tick_sum;
  logic       dsec_tick;
  logic       fast_run;
  logic [4:0] tenth_sum;
  logic       tenth_carry;
  logic [4:0] dsec_sum;
  logic       dsec_carry;
  logic [6:0] sec_sum;
  logic       sec_carry;
  logic [6:0] min_sum;
  logic       min_carry;
  logic [4:0] hour_sum;
  hms_t       fast_adv;

  always_comb begin
    tick_sum    = {1'b0, tick_prescale} + 5'd1;
    dsec_tick   = (tick_sum >= TICKS_PER_TENTH);
    fast_run    = mode_flags[FLAG_FAST] && !mode_flags[FLAG_HOLD];

    tenth_sum   = {1'b0, tenths_accum} + {1'b0, scale_tenth};
    tenth_carry = (tenth_sum >= 5'd10);
    dsec_sum    = {1'b0, decisec_accum} + {1'b0, scale_dsec} + {4'd0, tenth_carry};
    dsec_carry  = (dsec_sum >= 5'd10);

    sec_sum     = {1'b0, fast_time.seconds} + {1'b0, scale_sec} + {6'd0, dsec_carry};
    sec_carry   = (sec_sum >= 7'd60);
    min_sum     = {1'b0, fast_time.minutes} + {3'd0, scale_min} + {6'd0, sec_carry};
    min_carry   = (min_sum >= 7'd60);
    hour_sum    = fast_time.hours + {4'd0, min_carry};

    fast_adv.seconds = sec_carry ? 6'(sec_sum - 7'd60) : sec_sum[5:0];
    fast_adv.minutes = min_carry ? 6'(min_sum - 7'd60) : min_sum[5:0];
    fast_adv.hours   = (hour_sum >= 5'd24) ? 5'd0 : hour_sum;
  end

  // Next state for a tick or an accepted packet.
  always_comb begin
    tick_prescale_next = tick_prescale;
    timeout_count_next = timeout_count;
    decisec_accum_next = decisec_accum;
    tenths_accum_next  = tenths_accum;
    mode_flags_next    = mode_flags;
    real_time_next     = real_time;
    fast_time_next     = fast_time;
    scale_min_next     = scale_min;
    scale_sec_next     = scale_sec;
    scale_dsec_next    = scale_dsec;
    scale_tenth_next   = scale_tenth;
    taken              = 1'b0;

    if (req_type) begin
      if (source_address == ADDR_ANY || src_addr == source_address) begin
        taken           = 1'b1;
        real_time_next  = load_hms(rx_real_hours, rx_real_minutes, rx_real_seconds);
        mode_flags_next = rx_mode_flags[3:0];
        if (pkt_length >= PKT_FAST_LEN) begin
          fast_time_next   = load_hms(rx_fast_hours, rx_fast_minutes, rx_fast_seconds);
          scale_min_next   = scale_q6000;
          scale_sec_next   = sec_full[5:0];
          scale_dsec_next  = dsec_full[3:0];
          scale_tenth_next = tenth_full[3:0];
        end else begin
          fast_time_next   = '0;
          scale_min_next   = '0;
          scale_sec_next   = '0;
          scale_dsec_next  = '0;
          scale_tenth_next = '0;
        end
        decisec_accum_next = '0;
        tenths_accum_next  = '0;
        timeout_count_next = timeout_limit;
      end
    end else begin
      tick_prescale_next = dsec_tick ? 4'(tick_sum - TICKS_PER_TENTH) : tick_sum[3:0];
      if (dsec_tick) begin
        if (timeout_count != 8'd0) begin
          timeout_count_next = timeout_count - 8'd1;
        end
        if (fast_run) begin
          tenths_accum_next  = tenth_carry ? 4'(tenth_sum - 5'd10) : tenth_sum[3:0];
          decisec_accum_next = dsec_carry ? 4'(dsec_sum - 5'd10) : dsec_sum[3:0];
          fast_time_next     = fast_adv;
        end
      end
    end

    timed_out_next = (timeout_limit != 8'd0) && (timeout_count_next == 8'd0);
  end

  // State registers, updated on every accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_prescale <= '0;
      timeout_count <= '0;
      decisec_accum <= '0;
      tenths_accum  <= '0;
      mode_flags    <= '0;
      real_time     <= '0;
      fast_time     <= '0;
      scale_min     <= '0;
      scale_sec     <= '0;
      scale_dsec    <= '0;
      scale_tenth   <= '0;
    end else if (accept) begin
      tick_prescale <= tick_prescale_next;
      timeout_count <= timeout_count_next;
      decisec_accum <= decisec_accum_next;
      tenths_accum  <= tenths_accum_next;
      mode_flags    <= mode_flags_next;
      real_time     <= real_time_next;
      fast_time     <= fast_time_next;
      scale_min     <= scale_min_next;
      scale_sec     <= scale_sec_next;
      scale_dsec    <= scale_dsec_next;
      scale_tenth   <= scale_tenth_next;
    end
  end

  // Mode code from the fast and hold flags.
  logic [1:0] mode_next;

  always_comb begin
    case ({mode_flags_next[FLAG_HOLD], mode_flags_next[FLAG_FAST]})
      2'b00:   mode_next = MODE_REAL;
      2'b01:   mode_next = MODE_FAST_RUN;
      2'b11:   mode_next = MODE_FAST_HOLD;
      default: mode_next = MODE_HOLD_ONLY;
    endcase
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload, loaded with each accepted beat.
  always_ff @(posedge clk) begin
    if (accept) begin
      packet_taken     <= taken;
      timed_out        <= timed_out_next;
      clock_mode       <= mode_next;
      fast_ampm        <= mode_flags_next[FLAG_FAST_12];
      real_ampm        <= mode_flags_next[FLAG_REAL_12];
      fast_hours_out   <= timed_out_next ? 5'd0 : fast_time_next.hours;
      fast_minutes_out <= timed_out_next ? 6'd0 : fast_time_next.minutes;
      fast_seconds_out <= timed_out_next ? 6'd0 : fast_time_next.seconds;
      real_hours_out   <= timed_out_next ? 5'd0 : real_time_next.hours;
      real_minutes_out <= timed_out_next ? 6'd0 : real_time_next.minutes;
      real_seconds_out <= timed_out_next ? 6'd0 : real_time_next.seconds;
    end
  end

endmodule

[sim/sfc_checker.sv]
// Request codes shared by the scaled fast clock bench, and the checker that
// mirrors the clock state from the accepted beats and compares every result.
// Depends on sfc_pkg from the design.
package sfc_tb_pkg;

  // Kind of an input beat.
  localparam logic REQ_TICK   = 1'b0;
  localparam logic REQ_PACKET = 1'b1;

endpackage

module sfc_checker
  import sfc_pkg::*, sfc_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        req_type,
  input  logic [7:0]  src_addr,
  input  logic [7:0]  pkt_length,
  input  logic [7:0]  rx_real_hours,
  input  logic [7:0]  rx_real_minutes,
  input  logic [7:0]  rx_real_seconds,
  input  logic [7:0]  rx_mode_flags,
  input  logic [7:0]  rx_fast_hours,
  input  logic [7:0]  rx_fast_minutes,
  input  logic [7:0]  rx_fast_seconds,
  input  logic [15:0] rx_scale,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        packet_taken,
  input  logic        timed_out,
  input  logic [1:0]  clock_mode,
  input  logic        fast_ampm,
  input  logic        real_ampm,
  input  logic [4:0]  fast_hours_out,
  input  logic [5:0]  fast_minutes_out,
  input  logic [5:0]  fast_seconds_out,
  input  logic [4:0]  real_hours_out,
  input  logic [5:0]  real_minutes_out,
  input  logic [5:0]  real_seconds_out,
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // What one result beat shows.
  typedef struct packed {
    logic       taken;
    logic       stale;
    logic [1:0] mode;
    logic       fast_12h;
    logic       real_12h;
    hms_t       fast_hms;
    hms_t       real_hms;
  } clock_view_t;

  // Mirrored configuration and clock state.
  logic [7:0]  src_filter;
  logic [7:0]  timeout_lim;
  logic [3:0]  prescale;
  logic [7:0]  countdown;
  logic [3:0]  decisec;
  logic [3:0]  tenths;
  logic [7:0]  flags;
  logic [15:0] scale;
  hms_t        real_now;
  hms_t        fast_now;

  clock_view_t expected_views[$];
  int          err_count = 0;
  int          result_count = 0;

  // A packet time that is out of range anywhere loads as midnight.
  function automatic hms_t packet_time(input logic [7:0] h, input logic [7:0] m,
                                       input logic [7:0] s);
    hms_t t;
    t = '0;
    if (h < 8'd24 && m < 8'd60 && s < 8'd60) begin
      t.hours   = h[4:0];
      t.minutes = m[5:0];
      t.seconds = s[5:0];
    end
    return t;
  endfunction

  // Adds whole seconds with carries through minutes and hours, modulo a day.
  function automatic hms_t add_seconds(input hms_t t, input int unsigned secs);
    int unsigned s;
    int unsigned m;
    hms_t r;
    s = t.seconds + secs;
    m = t.minutes + s / 60;
    r.seconds = 6'(s % 60);
    r.minutes = 6'(m % 60);
    r.hours   = 5'((t.hours + m / 60) % 24);
    return r;
  endfunction

  // One decisecond: count the timeout down and, when running fast, add the
  // scale in tenths with the tenths carry taken at ten.
  function automatic void tenth_elapsed();
    int unsigned whole;
    int unsigned part;
    if (countdown != 8'd0) countdown = countdown - 8'd1;
    if ({flags[FLAG_HOLD], flags[FLAG_FAST]} != 2'b01) return;
    whole = decisec + scale / 10;
    part  = tenths + scale % 10;
    if (part >= 10) begin
      whole++;
      part -= 10;
    end
    if (whole >= 10) fast_now = add_seconds(fast_now, whole / 10);
    decisec = 4'(whole % 10);
    tenths  = 4'(part);
  endfunction

  // Applies the beat on the input ports to the mirrored state and returns
  // the result it should produce.
  function automatic clock_view_t step_clock();
    clock_view_t v;
    logic [4:0]  next_tick;
    logic [1:0]  run_bits;
    v = '0;
    if (req_type == REQ_PACKET) begin
      if (src_filter == ADDR_ANY || src_addr == src_filter) begin
        v.taken  = 1'b1;
        real_now = packet_time(rx_real_hours, rx_real_minutes, rx_real_seconds);
        flags    = rx_mode_flags;
        if (pkt_length >= PKT_FAST_LEN) begin
          fast_now = packet_time(rx_fast_hours, rx_fast_minutes, rx_fast_seconds);
          scale    = rx_scale;
        end else begin
          fast_now = '0;
          scale    = '0;
        end
        decisec   = '0;
        tenths    = '0;
        countdown = timeout_lim;
      end
    end else begin
      next_tick = {1'b0, prescale} + 5'd1;
      if (next_tick >= TICKS_PER_TENTH) begin
        next_tick = next_tick - TICKS_PER_TENTH;
        tenth_elapsed();
      end
      prescale = next_tick[3:0];
    end
    v.stale  = (timeout_lim != 8'd0 && countdown == 8'd0);
    run_bits = {flags[FLAG_HOLD], flags[FLAG_FAST]};
    case (run_bits)
      2'b00:   v.mode = MODE_REAL;
      2'b01:   v.mode = MODE_FAST_RUN;
      2'b11:   v.mode = MODE_FAST_HOLD;
      default: v.mode = MODE_HOLD_ONLY;
    endcase
    v.fast_12h = flags[FLAG_FAST_12];
    v.real_12h = flags[FLAG_REAL_12];
    if (!v.stale) begin
      v.fast_hms = fast_now;
      v.real_hms = real_now;
    end
    return v;
  endfunction

  // Four-state compare so that an unknown output never slips through.
  function automatic void check_field(input string label, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      err_count++;
      if (err_count <= 10)
        $display("MISMATCH result %0d %s: expected %0d, got %0d",
                 result_count, label, want, got);
    end
  endfunction

  // Results are compared before this edge's input beat is predicted, so a
  // stray result can never pair with an expectation made in the same cycle.
  always @(posedge clk) begin
    clock_view_t want;
    if (rst) begin
      src_filter  = ADDR_ANY;
      timeout_lim = 8'd50;
      prescale    = '0;
      countdown   = '0;
      decisec     = '0;
      tenths      = '0;
      flags       = '0;
      scale       = '0;
      real_now    = '0;
      fast_now    = '0;
      expected_views.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_SOURCE_ADDRESS: src_filter  = cfg_data;
          CFG_TIMEOUT_LIMIT:  timeout_lim = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_views.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("MISMATCH result %0d arrived with nothing expected", result_count);
        end else begin
          want = expected_views.pop_front();
          check_field("packet_taken", 32'(want.taken), 32'(packet_taken));
          check_field("timed_out", 32'(want.stale), 32'(timed_out));
          check_field("clock_mode", 32'(want.mode), 32'(clock_mode));
          check_field("fast_ampm", 32'(want.fast_12h), 32'(fast_ampm));
          check_field("real_ampm", 32'(want.real_12h), 32'(real_ampm));
          check_field("fast_hours_out", 32'(want.fast_hms.hours), 32'(fast_hours_out));
          check_field("fast_minutes_out", 32'(want.fast_hms.minutes),
                      32'(fast_minutes_out));
          check_field("fast_seconds_out", 32'(want.fast_hms.seconds),
                      32'(fast_seconds_out));
          check_field("real_hours_out", 32'(want.real_hms.hours), 32'(real_hours_out));
          check_field("real_minutes_out", 32'(want.real_hms.minutes),
                      32'(real_minutes_out));
          check_field("real_seconds_out", 32'(want.real_hms.seconds),
                      32'(real_seconds_out));
        end
        result_count++;
      end
      if (in_valid && in_ready) expected_views.push_back(step_clock());
    end
    outstanding <= expected_views.size();
    mismatches  <= err_count;
  end

endmodule

[sim/tb_scaled_fast_clock_with_sync_unit.sv]
// Bench top for the scaled fast clock: clock, reset, configuration phases,
// directed and random beats, the result sink and the verdict.
// Depends on sfc_pkg, the design top and sfc_checker.sv.
module tb_scaled_fast_clock_with_sync_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import sfc_pkg::*;
  import sfc_tb_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASE_BEATS   = 88;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASES        = 6;

  // One input beat as the sender holds it.
  typedef struct packed {
    logic        kind;
    logic [7:0]  src;
    logic [7:0]  len;
    logic [7:0]  real_h;
    logic [7:0]  real_m;
    logic [7:0]  real_s;
    logic [7:0]  flags;
    logic [7:0]  fast_h;
    logic [7:0]  fast_m;
    logic [7:0]  fast_s;
    logic [15:0] scale;
  } clock_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = CFG_SOURCE_ADDRESS;
  logic [7:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        req_type = REQ_TICK;
  logic [7:0]  src_addr = '0;
  logic [7:0]  pkt_length = '0;
  logic [7:0]  rx_real_hours = '0;
  logic [7:0]  rx_real_minutes = '0;
  logic [7:0]  rx_real_seconds = '0;
  logic [7:0]  rx_mode_flags = '0;
  logic [7:0]  rx_fast_hours = '0;
  logic [7:0]  rx_fast_minutes = '0;
  logic [7:0]  rx_fast_seconds = '0;
  logic [15:0] rx_scale = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        packet_taken;
  logic        timed_out;
  logic [1:0]  clock_mode;
  logic        fast_ampm;
  logic        real_ampm;
  logic [4:0]  fast_hours_out;
  logic [5:0]  fast_minutes_out;
  logic [5:0]  fast_seconds_out;
  logic [4:0]  real_hours_out;
  logic [5:0]  real_minutes_out;
  logic [5:0]  real_seconds_out;

  int mismatches;
  int outstanding;
  int cycle_count = 0;
  int sink_stall = 0;
  bit idling = 1'b0;

  always #5 clk = ~clk;

  scaled_fast_clock_with_sync_unit u_top (.*);

  sfc_checker u_check (.*);

  // Result sink: ready by default, dropped in random bursts while idling.
  always @(posedge clk) begin
    if (sink_stall != 0) begin
      sink_stall <= sink_stall - 1;
      out_ready  <= 1'b0;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      sink_stall <= $urandom_range(0, 4);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // A beat of the given kind with every field random.
  function automatic clock_beat_t any_beat(input logic kind);
    clock_beat_t b;
    b.kind   = kind;
    b.src    = 8'($urandom);
    b.len    = 8'($urandom);
    b.real_h = 8'($urandom);
    b.real_m = 8'($urandom);
    b.real_s = 8'($urandom);
    b.flags  = 8'($urandom);
    b.fast_h = 8'($urandom);
    b.fast_m = 8'($urandom);
    b.fast_s = 8'($urandom);
    b.scale  = 16'($urandom);
    return b;
  endfunction

  function automatic clock_beat_t packet_beat(
      input logic [7:0] src, input logic [7:0] len, input logic [7:0] rh,
      input logic [7:0] rm, input logic [7:0] rs, input logic [7:0] flags,
      input logic [7:0] fh, input logic [7:0] fm, input logic [7:0] fs,
      input logic [15:0] scale);
    clock_beat_t b;
    b = '{kind: REQ_PACKET, src: src, len: len, real_h: rh, real_m: rm, real_s: rs,
          flags: flags, fast_h: fh, fast_m: fm, fast_s: fs, scale: scale};
    return b;
  endfunction

  // A valid time of day, often just short of midnight to exercise the wrap.
  function automatic logic [23:0] random_hms();
    if ($urandom_range(0, 3) == 0)
      return {8'd23, 8'd59, 8'($urandom_range(50, 59))};
    return {8'($urandom_range(0, 23)), 8'($urandom_range(0, 59)),
            8'($urandom_range(0, 59))};
  endfunction

  // Mostly ticks; packets are largely well formed and addressed to the
  // current source, the rest are raw noise.
  function automatic clock_beat_t random_beat(input logic [7:0] home);
    clock_beat_t b;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 78) return any_beat(REQ_TICK);
    if (pick >= 94) return any_beat(REQ_PACKET);
    b = any_beat(REQ_PACKET);
    if (home != ADDR_ANY && $urandom_range(0, 9) != 0) b.src = home;
    b.len = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 13))
                                        : 8'($urandom_range(14, 255));
    {b.real_h, b.real_m, b.real_s} = random_hms();
    {b.fast_h, b.fast_m, b.fast_s} = random_hms();
    if ($urandom_range(0, 1) == 0) begin
      b.flags[FLAG_FAST] = 1'b1;
      b.flags[FLAG_HOLD] = 1'b0;
    end
    case ($urandom_range(0, 3))
      0:       b.scale = 16'($urandom_range(0, 30));
      1:       b.scale = 16'($urandom_range(0, 2000));
      2:       b.scale = 16'($urandom);
      default: b.scale = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
    endcase
    return b;
  endfunction

  // Presents one beat and holds it until the block takes it.
  task automatic send_beat(input clock_beat_t b);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    req_type        <= b.kind;
    src_addr        <= b.src;
    pkt_length      <= b.len;
    rx_real_hours   <= b.real_h;
    rx_real_minutes <= b.real_m;
    rx_real_seconds <= b.real_s;
    rx_mode_flags   <= b.flags;
    rx_fast_hours   <= b.fast_h;
    rx_fast_minutes <= b.fast_m;
    rx_fast_seconds <= b.fast_s;
    rx_scale        <= b.scale;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Holds the sender off until every expected result has been taken.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    clock_beat_t opening[$];
    logic [7:0]  phase_addr[PHASES];
    logic [7:0]  phase_limit[PHASES];

    // Directed opening, run with the reset configuration. The first tick
    // sees the block timed out; the large scale then wraps the fast time
    // past midnight on the first decisecond.
    opening.push_back(any_beat(REQ_TICK));
    opening.push_back(packet_beat(8'h12, 8'd14, 8'd23, 8'd59, 8'd59, 8'h01,
                                  8'd23, 8'd59, 8'd59, 16'hFFFF));
    repeat (10) opening.push_back(any_beat(REQ_TICK));
    // Out-of-range hours, minutes and seconds, short and long packets.
    opening.push_back(packet_beat(8'hFF, 8'd255, 8'd24, 8'd0, 8'd0, 8'h03,
                                  8'd12, 8'd60, 8'd0, 16'h0000));
    opening.push_back(packet_beat(8'h00, 8'd13, 8'd0, 8'd60, 8'd0, 8'h02,
                                  8'hFF, 8'hFF, 8'hFF, 16'hFFFF));
    opening.push_back(packet_beat(8'h80, 8'd0, 8'd0, 8'd0, 8'd60, 8'h00,
                                  8'd1, 8'd1, 8'd1, 16'h0001));
    opening.push_back(packet_beat(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                  8'hFF, 8'hFF, 8'hFF, 16'hFFFF));
    opening.push_back(packet_beat(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                  8'h00, 8'h00, 8'h00, 16'h0000));
    opening.push_back(packet_beat(8'h7F, 8'd14, 8'd12, 8'd34, 8'd56, 8'h0D,
                                  8'd1, 8'd2, 8'd3, 16'd15));
    repeat (3) opening.push_back(any_beat(REQ_TICK));

    // Source filter and timeout per phase, extremes included.
    phase_addr  = '{8'h5A, 8'h00, ADDR_ANY, 8'h00, ADDR_ANY, 8'hFE};
    phase_limit = '{8'd0, 8'd1, 8'd255, 8'd3, 8'd0, 8'd50};
    phase_addr[3]  = 8'($urandom_range(0, 254));
    phase_limit[4] = 8'($urandom_range(2, 20));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (opening[i]) send_beat(opening[i]);

    // Random phases; idling is chosen per stretch and is off in the last one.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_reg(CFG_SOURCE_ADDRESS, phase_addr[p]);
      write_reg(CFG_TIMEOUT_LIMIT, phase_limit[p]);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (n % 22 == 0) idling <= (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
        send_beat(random_beat(phase_addr[p]));
      end
    end
    settle();

    if (mismatches == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[filelist.f]
design/sfc_pkg.sv
design/scaled_fast_clock_with_sync_unit.sv
sim/sfc_checker.sv
sim/tb_scaled_fast_clock_with_sync_unit.sv
